/* hdl/fdlc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlc_pkg: shared definitions for the fractional delay line
// Sample and delay types, coefficient width, saturation limits and the
// control word of the cubic evaluator.
// ----------------------------------------------------------------------------
package fdlc_pkg;

   localparam int SAMPLE_W      = 24;
   localparam int DELAY_W       = 24;
   localparam int DEPTH_DEF     = 65536;
   localparam int FRAC_BITS_DEF = 8;
   localparam int NUM_TAPS      = 4;
   localparam int HORNER_STEPS  = 3;

   // Coefficients and Horner partial results stay below 13 * 2^23 in magnitude
   localparam int COEF_W = 28;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic        [DELAY_W-1:0]  delay_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   localparam coef_type SAT_MAX = coef_type'(8388607);
   localparam coef_type SAT_MIN = coef_type'(-8388608);

   // load: take the four taps and form coefficients; step: one Horner step
   typedef struct packed {
      logic load;
      logic step;
   } cubic_ctl_type;

endpackage

/* hdl/fdlc_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlc_channels: valid/ready channel interfaces
// Input sample channel, interpolated output channel and delay write channel.
// ----------------------------------------------------------------------------
interface fdlc_req_if;
   import fdlc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface fdlc_rsp_if;
   import fdlc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface fdlc_csr_if;
   import fdlc_pkg::*;
   logic      valid;
   logic      ready;
   delay_type delay_q8;
   modport source (output valid, output delay_q8, input ready);
   modport sink   (input valid, input delay_q8, output ready);
endinterface

/* hdl/fractional_delay_line_cubic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_delay_line_cubic: audio delay line with cubic interpolation
// Circular sample store, fractional read position, four-tap cubic output.
// ----------------------------------------------------------------------------
// Each accepted input word is written into a DEPTH-entry sample store and one
// output word follows: the cubic interpolation of the four stored samples
// around the position write pointer minus delay, with the delay in samples
// and FRAC_BITS fraction bits, taken modulo the store size. One item occupies
// the block from one acceptance to the next: the acceptance, the four reads
// through the single RAM read port, the coefficients, three Horner steps on
// one shared multiplier and the load of the output register, which waits
// while an earlier word is not yet taken. A finished word waits in the output
// register while the next input is taken. After a delay write the delay is
// reduced modulo the store span, and the input stalls while that runs.
// The store needs no clearing pass: a fill count marks entries not yet
// written since reset, and these read as zero.
module fractional_delay_line_cubic #(
   parameter int DEPTH     = fdlc_pkg::DEPTH_DEF,
   parameter int FRAC_BITS = fdlc_pkg::FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   fdlc_req_if.sink      req_ch,
   fdlc_rsp_if.source    rsp_ch,
   fdlc_csr_if.sink      csr_ch
);
   import fdlc_pkg::*;

   localparam int AW     = $clog2(DEPTH);
   localparam int POS_W  = AW + FRAC_BITS;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int RCNT_W = $clog2(NUM_TAPS + 1);
   localparam int TAP_W  = $clog2(NUM_TAPS);
   localparam logic [POS_W:0]    SPAN = (POS_W+1)'(longint'(DEPTH) << FRAC_BITS);
   localparam logic [AW-1:0]     LAST = AW'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL = FILL_W'(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COEF,
      ST_EVAL,
      ST_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        wp_ff, wp_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [RCNT_W-1:0]    rd_cnt_ff, rd_cnt_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [1:0]           ev_cnt_ff, ev_cnt_in;
   sample_type           ys_ff [NUM_TAPS];
   sample_type           ys_in [NUM_TAPS];
   logic                 rsp_valid_ff, rsp_valid_in;
   sample_type           rsp_data_ff, rsp_data_in;

   logic [POS_W-1:0]     delay_red;
   logic                 dmod_busy;
   logic                 req_accept;
   logic [POS_W:0]       pos_sum;
   logic [POS_W:0]       pos_wrap;
   logic [AW-1:0]        idx_m1, idx_p1, idx_p2;
   logic [AW-1:0]        rd_addr;
   logic                 rd_en;
   logic [SAMPLE_W-1:0]  ram_q;
   cubic_ctl_type        cubic_ctl;
   sample_type           cubic_result;

   // delay register and its reduction modulo the store span
   fdlc_dmod #(
      .DEPTH     (DEPTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_dmod (
      .clock     (clock),
      .reset     (reset),
      .csr_ch    (csr_ch),
      .delay_red (delay_red),
      .busy      (dmod_busy)
   );

   // sample store
   fdlc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (wp_ff),
      .wr_data (req_ch.sample_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // interpolator
   fdlc_cubic #(
      .FRAC_BITS (FRAC_BITS)
   ) u_cubic (
      .clock  (clock),
      .ctl    (cubic_ctl),
      .y_in   (ys_ff),
      .frac   (frac_ff),
      .result (cubic_result)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && !dmod_busy;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // read position: write pointer minus delay, wrapped into the span
   always_comb begin
      pos_sum  = {1'b0, wp_ff, {FRAC_BITS{1'b0}}} + (SPAN - {1'b0, delay_red});
      pos_wrap = (pos_sum >= SPAN) ? pos_sum - SPAN : pos_sum;
   end

   // wrapped neighbor addresses
   always_comb begin
      idx_m1 = (idx_ff == '0)   ? LAST : idx_ff - 1'b1;
      idx_p1 = (idx_ff == LAST) ? '0   : idx_ff + 1'b1;
      idx_p2 = (idx_p1 == LAST) ? '0   : idx_p1 + 1'b1;
   end

   always_comb begin
      case (rd_cnt_ff[TAP_W-1:0])
         2'd0:    rd_addr = idx_m1;
         2'd1:    rd_addr = idx_ff;
         2'd2:    rd_addr = idx_p1;
         default: rd_addr = idx_p2;
      endcase
   end

   assign rd_en = (state_ff == ST_READ) && (rd_cnt_ff != RCNT_W'(NUM_TAPS));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_ok_in     = rd_ok_ff;
      ev_cnt_in    = ev_cnt_ff;
      ys_in        = ys_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cubic_ctl    = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               idx_in    = pos_wrap[POS_W-1:FRAC_BITS];
               frac_in   = pos_wrap[FRAC_BITS-1:0];
               wp_in     = (wp_ff == LAST) ? '0 : wp_ff + 1'b1;
               fill_in   = (fill_ff == FULL) ? fill_ff : fill_ff + 1'b1;
               rd_cnt_in = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            // entries past the fill count were never written: read as zero
            rd_ok_in  = FILL_W'(rd_addr) < fill_ff;
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff != '0) begin
               ys_in[TAP_W'(rd_cnt_ff - 1'b1)] = rd_ok_ff ? sample_type'(ram_q) : '0;
            end
            if (rd_cnt_ff == RCNT_W'(NUM_TAPS)) begin
               state_in = ST_COEF;
            end
         end
         ST_COEF: begin
            cubic_ctl.load = 1'b1;
            ev_cnt_in      = '0;
            state_in       = ST_EVAL;
         end
         ST_EVAL: begin
            cubic_ctl.step = 1'b1;
            ev_cnt_in      = ev_cnt_ff + 1'b1;
            if (ev_cnt_ff == 2'(HORNER_STEPS - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = cubic_result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rd_cnt_ff    <= '0;
         ev_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rd_cnt_ff    <= rd_cnt_in;
         ev_cnt_ff    <= ev_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      rd_ok_ff    <= rd_ok_in;
      ys_ff       <= ys_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = rsp_data_ff;

`ifndef SYNTH
   // fill count never runs past the store size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("fill count beyond store depth");

   // wrapped read index stays inside the store
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (idx_ff <= LAST))
      else $error("read index outside store");

   // a new output word only comes from the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("output word raised outside output state");

   // an item is never taken while the delay is still being reduced
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      dmod_busy |-> (state_ff != ST_IDLE) || !req_accept)
      else $error("item accepted during delay reduction");
`endif

endmodule

/* hdl/fdlc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlc_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fdlc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* hdl/fdlc_dmod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlc_dmod: delay register with modulo reduction
// Takes a delay word and reduces it modulo the store span (DEPTH samples
// with FRAC_BITS fraction bits): the fraction passes through, the integer
// part is reduced modulo DEPTH by a reciprocal multiply, a multiply back and
// one correcting subtract.
// ----------------------------------------------------------------------------
module fdlc_dmod #(
   parameter int DEPTH     = fdlc_pkg::DEPTH_DEF,
   parameter int FRAC_BITS = fdlc_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   fdlc_csr_if.sink                               csr_ch,
   output logic [$clog2(DEPTH)+FRAC_BITS-1:0]     delay_red,
   output logic                                   busy
);
   import fdlc_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int POS_W = AW + FRAC_BITS;
   localparam int INT_W = DELAY_W - FRAC_BITS;
   localparam int RW    = AW + 2;
   localparam int QP_W  = INT_W + AW + 1;
   // floor(2^INT_W / DEPTH): the quotient estimate is exact or one low
   localparam logic [INT_W-1:0] RECIP     = INT_W'((longint'(1) << INT_W) / DEPTH);
   localparam logic [AW:0]      DEPTH_C   = (AW+1)'(DEPTH);
   localparam logic [RW-1:0]    DEPTH_R   = RW'(DEPTH);
   localparam logic [1:0]       LAST_STEP = 2'd2;

   logic [INT_W-1:0]     int_ff, int_in;
   logic [FRAC_BITS-1:0] fr_ff, fr_in;
   logic [INT_W-1:0]     q_ff, q_in;
   logic [RW-1:0]        r_ff, r_in;
   logic [POS_W-1:0]     rem_ff, rem_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [2*INT_W-1:0]   q_prod;
   logic [QP_W-1:0]      back_prod;
   logic [RW-1:0]        r_fix;

   // quotient estimate, remainder before and after the correcting subtract
   always_comb begin
      q_prod    = int_ff * RECIP;
      back_prod = q_ff * DEPTH_C;
      r_fix     = (r_ff >= DEPTH_R) ? r_ff - DEPTH_R : r_ff;
   end

   always_comb begin
      int_in  = int_ff;
      fr_in   = fr_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         int_in  = csr_ch.delay_q8[DELAY_W-1:FRAC_BITS];
         fr_in   = csr_ch.delay_q8[FRAC_BITS-1:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = q_prod[2*INT_W-1:INT_W];
         r_in   = RW'(int_ff) - back_prod[RW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            rem_in  = {r_fix[AW-1:0], fr_ff};
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      int_ff <= int_in;
      fr_ff  <= fr_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
   end

   assign csr_ch.ready = !busy_ff;
   assign delay_red    = rem_ff;
   assign busy         = busy_ff;

endmodule

/* hdl/fdlc_cubic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlc_cubic: cubic interpolation by Horner steps
// Forms the four polynomial coefficients from the taps, then runs three
// multiply-add-round steps on one shared multiplier and saturates.
// ----------------------------------------------------------------------------
module fdlc_cubic #(
   parameter int FRAC_BITS = fdlc_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  fdlc_pkg::cubic_ctl_type ctl,
   input  fdlc_pkg::sample_type   y_in [fdlc_pkg::NUM_TAPS],
   input  logic [FRAC_BITS-1:0]   frac,
   output fdlc_pkg::sample_type   result
);
   import fdlc_pkg::*;

   localparam int PROD_W = COEF_W + FRAC_BITS + 1;
   localparam int ACC_W  = COEF_W + FRAC_BITS + 2;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(longint'(1) << (FRAC_BITS - 1));

   coef_type y0, y1, y2, y3;
   coef_type a0, a1, a2;
   coef_type a1_ff, a2_ff, a3_ff, t_ff;
   logic [1:0] sel_ff;
   coef_type coef_sel;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  acc_shr;

   // coefficients of the cubic through the four taps
   always_comb begin
      y0 = coef_type'(y_in[0]);
      y1 = coef_type'(y_in[1]);
      y2 = coef_type'(y_in[2]);
      y3 = coef_type'(y_in[3]);
      a0 = y3 - y2 - y0 + y1;
      a1 = y0 - y1 - a0;
      a2 = y2 - y0;
   end

   always_comb begin
      case (sel_ff)
         2'd0:    coef_sel = a1_ff;
         2'd1:    coef_sel = a2_ff;
         default: coef_sel = a3_ff;
      endcase
   end

   // t * f + c * 2^FB, rounded half up and scaled back
   always_comb begin
      prod    = t_ff * $signed({1'b0, frac});
      acc     = ACC_W'(prod) + (ACC_W'(coef_sel) <<< FRAC_BITS) + HALF;
      acc_shr = acc >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         t_ff   <= a0;
         a1_ff  <= a1;
         a2_ff  <= a2;
         a3_ff  <= y1;
         sel_ff <= 2'd0;
      end else if (ctl.step) begin
         t_ff   <= coef_type'(acc_shr[COEF_W-1:0]);
         sel_ff <= sel_ff + 2'd1;
      end
   end

   // clamp to the sample range
   always_comb begin
      if (t_ff > SAT_MAX) begin
         result = sample_type'(SAT_MAX[SAMPLE_W-1:0]);
      end else if (t_ff < SAT_MIN) begin
         result = sample_type'(SAT_MIN[SAMPLE_W-1:0]);
      end else begin
         result = sample_type'(t_ff[SAMPLE_W-1:0]);
      end
   end

endmodule

/* dv/fdlc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlc_checker: predicts and checks the delayed, interpolated output words
// Watches the sample, output and delay channels. It keeps its own sample store,
// write pointer and delay, and works out the cubic output for every accepted
// input word. Each accepted output word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module fdlc_checker (
   input  logic clock,
   input  logic reset,
   fdlc_req_if  req_ch,
   fdlc_rsp_if  rsp_ch,
   fdlc_csr_if  csr_ch,
   output int   mismatch_count,
   output int   pending_count,
   output int   checked_count
);
   import fdlc_pkg::*;

   localparam longint SPAN   = longint'(DEPTH_DEF) << FRAC_BITS_DEF;
   localparam longint ONE_Q  = longint'(1) << FRAC_BITS_DEF;
   localparam longint SAT_HI = 8388607;
   localparam longint SAT_LO = -8388608;

   sample_type  tap_store [DEPTH_DEF];
   int unsigned wr_ptr;
   delay_type   delay_setting;
   sample_type  expected_samples [$];
   int          fails;
   int          checked;

   // Store the new word, interpolate at write pointer minus delay, advance
   function automatic sample_type predict_delayed_sample(sample_type s);
      longint pos;
      longint idx;
      longint frac;
      longint acc;
      longint y [4];
      longint coef [3];
      tap_store[wr_ptr] = s;
      pos = ((longint'(wr_ptr) << FRAC_BITS_DEF) + SPAN
             - (longint'(delay_setting) % SPAN)) % SPAN;
      idx  = pos >> FRAC_BITS_DEF;
      frac = pos % ONE_Q;
      // taps at -1, 0, +1, +2 around the integer read position
      for (int k = 0; k < NUM_TAPS; k++) begin
         y[k] = tap_store[(idx + DEPTH_DEF - 1 + k) % DEPTH_DEF];
      end
      acc     = y[3] - y[2] - y[0] + y[1];
      coef[0] = y[0] - y[1] - acc;
      coef[1] = y[2] - y[0];
      coef[2] = y[1];
      // Horner steps, each rounded half up (arithmetic shift is a floor)
      for (int k = 0; k < HORNER_STEPS; k++) begin
         acc = (acc * frac + coef[k] * ONE_Q + ONE_Q / 2) >>> FRAC_BITS_DEF;
      end
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      wr_ptr = (wr_ptr + 1) % DEPTH_DEF;
      return sample_type'(acc);
   endfunction

   // Handshakes are seen with the values from before the edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (tap_store[k]) tap_store[k] = '0;
         wr_ptr        = 0;
         delay_setting = '0;
         expected_samples.delete();
         fails   = 0;
         checked = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            delay_setting = csr_ch.delay_q8;
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_samples.push_back(predict_delayed_sample(req_ch.sample_in));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_samples.size() == 0) begin
               if (fails < 10) begin
                  $display("unexpected output word %0d at %0t", rsp_ch.sample_out, $realtime);
               end
               fails++;
            end else begin
               sample_type want;
               want = expected_samples.pop_front();
               if (rsp_ch.sample_out !== want) begin
                  if (fails < 10) begin
                     $display("output word %0d: expected %0d, got %0d", checked, want,
                              rsp_ch.sample_out);
                  end
                  fails++;
               end
               checked++;
            end
         end
      end
      mismatch_count <= fails;
      pending_count  <= expected_samples.size();
      checked_count  <= checked;
   end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level of the fractional delay line regression
// Drives sample words and delay writes with random idling and one long output
// hold-off; a checker beside the block predicts and compares every output.
// ----------------------------------------------------------------------------
module tb;
   import fdlc_pkg::*;

   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         RANDOM_WORDS = 600;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         IDLE_PCT     = 35;
   localparam delay_type  DELAY_MAX    = delay_type'((DEPTH_DEF - 3) << FRAC_BITS_DEF);
   localparam delay_type  DELAY_HALF   = delay_type'(3 << (FRAC_BITS_DEF - 1));
   localparam delay_type  DELAY_FRAC   = delay_type'((4 << FRAC_BITS_DEF) - 1);
   localparam sample_type S_MAX        = sample_type'(8388607);
   localparam sample_type S_MIN        = sample_type'(-8388608);

   logic clock    = 1'b0;
   logic reset    = 1'b1;
   logic rsp_hold = 1'b0;
   int   idle_pct = IDLE_PCT;
   int   words_sent   = 0;
   int   delay_writes = 0;
   int   cycle_count  = 0;
   int   mismatch_count;
   int   pending_count;
   int   checked_count;

   fdlc_req_if req_if ();
   fdlc_rsp_if rsp_if ();
   fdlc_csr_if csr_if ();

   fractional_delay_line_cubic dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   fdlc_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_if),
      .rsp_ch         (rsp_if),
      .csr_ch         (csr_if),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // Output side: random stalls, forced low during a hold-off
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !rsp_hold && ($urandom_range(0, 99) >= idle_pct);
      end
   end

   function automatic sample_type random_sample();
      case ($urandom_range(0, 9))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return sample_type'(int'($urandom_range(0, 511)) - 256);
         default: return sample_type'($urandom());
      endcase
   endfunction

   // Offer one word after a random gap, return at the accepting edge
   task automatic send_sample(input sample_type s);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.sample_in <= s;
      do @(posedge clock); while (!req_if.ready);
      words_sent++;
   endtask

   // Delay write once every output word is back
   task automatic set_delay(input delay_type d);
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      csr_if.valid    <= 1'b1;
      csr_if.delay_q8 <= d;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      delay_writes++;
   endtask

   initial begin
      int        phase;
      int        directed_words;
      delay_type next_delay;
      req_if.valid     <= 1'b0;
      req_if.sample_in <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.delay_q8  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero delay: output is the word just written
      set_delay('0);
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample('0);
      send_sample(sample_type'(-1));
      send_sample(sample_type'(1));
      send_sample(sample_type'(24'h555555));
      send_sample(sample_type'(24'hAAAAAA));

      // half-sample delay over full-scale swings: overshoot saturates both ways
      set_delay(DELAY_HALF);
      repeat (2) begin
         send_sample(S_MIN);
         send_sample(S_MAX);
         send_sample(S_MAX);
         send_sample(S_MIN);
      end

      // largest delay reads taps from beyond the written history
      set_delay(DELAY_MAX);
      repeat (3) send_sample(random_sample());
      set_delay(DELAY_FRAC);
      repeat (3) send_sample(random_sample());
      set_delay(delay_type'(1));
      repeat (2) send_sample(random_sample());
      directed_words = words_sent;

      // random phases, each with its own delay
      phase = 0;
      while (words_sent < directed_words + RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0:       next_delay = '0;
            1:       next_delay = DELAY_MAX;
            2:       next_delay = {16'($urandom_range(0, DEPTH_DEF - 4)), 8'hFF};
            3:       next_delay = delay_type'($urandom_range(0, DELAY_MAX));
            default: next_delay = delay_type'($urandom_range(0, 48 << FRAC_BITS_DEF));
         endcase
         set_delay(next_delay);
         idle_pct <= (phase == 2 || phase == 5) ? 0 : IDLE_PCT;
         // long output hold-off while input keeps coming
         if (phase == 2) begin
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end
         repeat ($urandom_range(15, 50)) send_sample(random_sample());
         phase++;
      end
      req_if.valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (40) @(posedge clock);

      $display("Sent %0d sample words across %0d delay settings; %0d outputs checked.",
               words_sent, delay_writes, checked_count);
      $display("Covered zero and maximum delay, saturating overshoot and a %0d-cycle stall.",
               HOLD_CYCLES);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d outputs missing", mismatch_count, pending_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
